// ----- hdl/gdil_pkg.sv -----
// Package: shared constants, types and microcode ROM for the grid dilation core.
`default_nettype none

package gdil_pkg;

  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_COLS_DEF   = 256;
  localparam int MAX_RADIUS_DEF = 15;

  localparam int ROW_IN_W   = 8;
  localparam int COL_IN_W   = 8;
  localparam int RAD_CFG_W  = 4;
  localparam int DIM_CFG_W  = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WIDTH  = 2'd2
  } cfg_idx_t;

  // microcode step addresses
  typedef enum logic [3:0] {
    ST_CLR   = 4'd0,
    ST_IDLE  = 4'd1,
    ST_SETUP = 4'd2,
    ST_QCHK  = 4'd3,
    ST_QLOOP = 4'd4,
    ST_DRAIN = 4'd5,
    ST_EMIT  = 4'd6,
    ST_WRRD  = 4'd7,
    ST_WRWR  = 4'd8
  } step_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_NONE    = 3'd0,
    C_ALWAYS  = 3'd1,
    C_NOACC   = 3'd2,
    C_WRITE   = 3'd3,
    C_OUTSIDE = 3'd4,
    C_ROWMORE = 3'd5,
    C_CLRMORE = 3'd6,
    C_OUTBUSY = 3'd7
  } cond_t;

  typedef struct packed {
    logic  accept;   // take a request
    logic  setup;    // compute window, load row pointer
    logic  rd;       // read row word at pointer
    logic  qacc;     // read data feeds the hit accumulator
    logic  wr;       // write merged row word (if in bounds)
    logic  clr;      // write zero row word
    logic  ptr_inc;  // advance row pointer
    logic  emit;     // load result register
    cond_t hold;     // stay on this step while true
    cond_t jmp;      // else branch to target when true
    step_t target;
  } ctl_word_t;

  function automatic ctl_word_t ucode(input step_t pc);
    ctl_word_t w;
    w = '0;
    case (pc)
      ST_CLR: begin
        w.clr = 1'b1; w.ptr_inc = 1'b1; w.hold = C_CLRMORE;
      end
      ST_IDLE: begin
        w.accept = 1'b1; w.hold = C_NOACC;
      end
      ST_SETUP: begin
        w.setup = 1'b1; w.jmp = C_WRITE; w.target = ST_WRRD;
      end
      ST_QCHK: begin
        w.jmp = C_OUTSIDE; w.target = ST_EMIT;
      end
      ST_QLOOP: begin
        w.rd = 1'b1; w.qacc = 1'b1; w.ptr_inc = 1'b1; w.hold = C_ROWMORE;
      end
      ST_DRAIN: begin
        w.jmp = C_NONE;
      end
      ST_EMIT: begin
        w.emit = 1'b1; w.hold = C_OUTBUSY; w.jmp = C_ALWAYS; w.target = ST_IDLE;
      end
      ST_WRRD: begin
        w.rd = 1'b1;
      end
      ST_WRWR: begin
        w.wr = 1'b1; w.jmp = C_ALWAYS; w.target = ST_IDLE;
      end
      default: begin
        w.jmp = C_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gdil_if.sv -----
// Interfaces: request channel and result channel.
`default_nettype none

interface gdil_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [gdil_pkg::ROW_IN_W-1:0]   row;
  logic [gdil_pkg::COL_IN_W-1:0]   col;
  logic                            obstacle;

  modport source (output valid, op, row, col, obstacle, input ready);
  modport sink   (input valid, op, row, col, obstacle, output ready);
endinterface

interface gdil_out_if;
  logic valid;
  logic ready;
  logic inflated_obstacle;

  modport source (output valid, inflated_obstacle, input ready);
  modport sink   (input valid, inflated_obstacle, output ready);
endinterface

`default_nettype wire

// ----- hdl/gdil_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gdil_ram #(
  parameter int WIDTH = gdil_pkg::MAX_COLS_DEF,
  parameter int DEPTH = gdil_pkg::MAX_ROWS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/grid_obstacle_dilation_core.sv -----
// Top level: occupancy grid with square-window obstacle inflation, microcoded control.
// Write request: accepted in IDLE, then a read-modify-write of one row word (SETUP, WRRD,
//   WRWR, write skipped if out of bounds); the next request is taken back in IDLE.
// Query request: SETUP, QCHK, then QLOOP reads the clipped window rows (1..31), one row per
//   cycle on the grid RAM read port, then DRAIN and EMIT register the result; EMIT holds while
//   the result channel is busy. Out-of-bounds queries jump from QCHK to EMIT with no hit.
// Reset (sync, active low): control and config registers to defaults, then a clearing pass
//   zeroes every grid row; no request is taken during it (config writes still are).
`default_nettype none

module grid_obstacle_dilation_core #(
  parameter int MAX_ROWS   = gdil_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = gdil_pkg::MAX_COLS_DEF,
  parameter int MAX_RADIUS = gdil_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gdil_in_if.sink                                in_chan,
  gdil_out_if.source                             out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [gdil_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gdil_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int IDX_MAX = (ROW_W > COL_W) ? ROW_W : COL_W;
  // room for index + radius and for the 9-bit bounds
  localparam int CALC_W  = (IDX_MAX + 2 > 11) ? IDX_MAX + 2 : 11;

  // ---------------- configuration registers ----------------
  logic [gdil_pkg::RAD_CFG_W-1:0] cfg_radius_r;
  logic [gdil_pkg::DIM_CFG_W-1:0] cfg_height_r;
  logic [gdil_pkg::DIM_CFG_W-1:0] cfg_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radius_r <= '0;
      cfg_height_r <= gdil_pkg::DIM_RESET;
      cfg_width_r  <= gdil_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gdil_pkg::CFG_RADIUS: cfg_radius_r <= cfg_wdata[gdil_pkg::RAD_CFG_W-1:0];
        gdil_pkg::CFG_HEIGHT: cfg_height_r <= cfg_wdata[gdil_pkg::DIM_CFG_W-1:0];
        gdil_pkg::CFG_WIDTH:  cfg_width_r  <= cfg_wdata[gdil_pkg::DIM_CFG_W-1:0];
        default: ;  // unknown index: no effect
      endcase
    end
  end

  // ---------------- sequencer ----------------
  gdil_pkg::step_t     pc_r, pc_nxt;
  gdil_pkg::ctl_word_t ctl;

  assign ctl = gdil_pkg::ucode(pc_r);

  // ---------------- datapath registers ----------------
  logic                          op_r;
  logic [gdil_pkg::ROW_IN_W-1:0] row_r;
  logic [gdil_pkg::COL_IN_W-1:0] col_r;
  logic                          obst_r;
  logic                          inside_r, inside_nxt;
  logic [ROW_W-1:0]              r1_r;
  logic [COL_W-1:0]              c0_r, c1_r;
  logic [ROW_W-1:0]              ptr_r, ptr_nxt;
  logic                          hit_r, hit_nxt;
  logic                          acc_pend_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_data_r;

  logic accept;
  logic out_busy;

  assign in_chan.ready = ctl.accept;
  assign accept        = in_chan.valid & in_chan.ready;
  assign out_busy      = out_valid_r & ~out_chan.ready;

  // ---------------- window arithmetic (used in SETUP) ----------------
  logic [CALC_W-1:0] eff_h, eff_w, eff_r;
  logic [CALC_W-1:0] row_x, col_x;
  logic [CALC_W-1:0] r0_c, r1_c, c0_c, c1_c;

  always_comb begin
    eff_h = (CALC_W'(cfg_height_r) > CALC_W'(MAX_ROWS)) ? CALC_W'(MAX_ROWS)
                                                         : CALC_W'(cfg_height_r);
    eff_w = (CALC_W'(cfg_width_r) > CALC_W'(MAX_COLS)) ? CALC_W'(MAX_COLS)
                                                        : CALC_W'(cfg_width_r);
    eff_r = (CALC_W'(cfg_radius_r) > CALC_W'(MAX_RADIUS)) ? CALC_W'(MAX_RADIUS)
                                                           : CALC_W'(cfg_radius_r);
    row_x = CALC_W'(row_r);
    col_x = CALC_W'(col_r);

    inside_nxt = (row_x < eff_h) && (col_x < eff_w);

    // clip to [0, bound-1]; bound-1 only matters when in bounds
    r0_c = (row_x >= eff_r) ? row_x - eff_r : '0;
    r1_c = (row_x + eff_r < eff_h) ? row_x + eff_r : eff_h - CALC_W'(1);
    c0_c = (col_x >= eff_r) ? col_x - eff_r : '0;
    c1_c = (col_x + eff_r < eff_w) ? col_x + eff_r : eff_w - CALC_W'(1);
  end

  // ---------------- branch conditions ----------------
  function automatic logic cond_true(input gdil_pkg::cond_t c, input logic noacc,
                                     input logic wr_op, input logic outside,
                                     input logic rowmore, input logic clrmore,
                                     input logic busy);
    logic t;
    case (c)
      gdil_pkg::C_NONE:    t = 1'b0;
      gdil_pkg::C_ALWAYS:  t = 1'b1;
      gdil_pkg::C_NOACC:   t = noacc;
      gdil_pkg::C_WRITE:   t = wr_op;
      gdil_pkg::C_OUTSIDE: t = outside;
      gdil_pkg::C_ROWMORE: t = rowmore;
      gdil_pkg::C_CLRMORE: t = clrmore;
      gdil_pkg::C_OUTBUSY: t = busy;
      default:             t = 1'b0;
    endcase
    return t;
  endfunction

  logic c_noacc, c_write, c_outside, c_rowmore, c_clrmore;
  logic hold_t, jmp_t;

  always_comb begin
    c_noacc   = ~in_chan.valid;
    c_write   = ~op_r;
    c_outside = ~inside_r;
    c_rowmore = (ptr_r != r1_r);
    c_clrmore = (ptr_r != ROW_W'(MAX_ROWS - 1));
    hold_t = cond_true(ctl.hold, c_noacc, c_write, c_outside, c_rowmore, c_clrmore,
                       out_busy);
    jmp_t  = cond_true(ctl.jmp, c_noacc, c_write, c_outside, c_rowmore, c_clrmore,
                       out_busy);
    if (hold_t) begin
      pc_nxt = pc_r;
    end else if (jmp_t) begin
      pc_nxt = ctl.target;
    end else begin
      pc_nxt = gdil_pkg::step_t'(pc_r + 4'd1);
    end
  end

  // ---------------- grid RAM: one row word per entry ----------------
  logic                ram_we;
  logic [MAX_COLS-1:0] ram_wdata;
  logic [MAX_COLS-1:0] ram_rdata;
  logic [MAX_COLS-1:0] col_mask;
  logic [COL_W-1:0]    col_idx;

  assign col_idx = col_x[COL_W-1:0];
  assign ram_we  = (ctl.wr & inside_r) | ctl.clr;

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      // merge the written bit into the row word read back in WRRD
      ram_wdata[j] = ctl.clr ? 1'b0
                   : ((COL_W'(j) == col_idx) ? obst_r : ram_rdata[j]);
      col_mask[j]  = (COL_W'(j) >= c0_r) && (COL_W'(j) <= c1_r);
    end
  end

  gdil_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (ram_wdata),
    .re    (ctl.rd),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // ---------------- next-state datapath ----------------
  always_comb begin
    ptr_nxt = ptr_r;
    if (ctl.setup) begin
      ptr_nxt = op_r ? r0_c[ROW_W-1:0] : row_x[ROW_W-1:0];
    end else if (ctl.ptr_inc) begin
      ptr_nxt = ptr_r + ROW_W'(1);
    end

    hit_nxt = hit_r;
    if (ctl.setup) begin
      hit_nxt = 1'b0;
    end else if (acc_pend_r) begin
      hit_nxt = hit_r | (|(ram_rdata & col_mask));
    end

    out_valid_nxt = out_valid_r;
    if (ctl.emit && !out_busy) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= gdil_pkg::ST_CLR;
      ptr_r       <= '0;
      acc_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      ptr_r       <= ptr_nxt;
      acc_pend_r  <= ctl.qacc;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_chan.op;
      row_r  <= in_chan.row;
      col_r  <= in_chan.col;
      obst_r <= in_chan.obstacle;
    end
    if (ctl.setup) begin
      inside_r <= inside_nxt;
      r1_r     <= r1_c[ROW_W-1:0];
      c0_r     <= c0_c[COL_W-1:0];
      c1_r     <= c1_c[COL_W-1:0];
    end
    hit_r <= hit_nxt;
    if (ctl.emit && !out_busy) begin
      out_data_r <= hit_r;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.inflated_obstacle = out_data_r;

  // ---------------- assertions ----------------
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == gdil_pkg::ST_CLR) |-> !in_chan.ready)
    else $error("request taken during grid clear");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == gdil_pkg::ST_QLOOP) |-> !ram_we)
    else $error("grid write during query scan");

  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == gdil_pkg::ST_QLOOP) |-> (ptr_r <= r1_r))
    else $error("row pointer ran past window");

  a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (pc_r == gdil_pkg::ST_SETUP))
    else $error("accepted request not dispatched");

  a_outside_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == gdil_pkg::ST_EMIT) && !inside_r) |-> !hit_r)
    else $error("out-of-bounds query reports a hit");

endmodule

`default_nettype wire
